FILE: rtl/i3fx_pkg.sv
// ----------------------------------------------------------------------------
// i3fx_pkg: shared types and constants of the ID3v2.3 frame extractor
// Holds the parser phase codes, the result kinds, the result record and the
// frame ID table with its lookup function.
// ----------------------------------------------------------------------------
`default_nettype none

package i3fx_pkg;

    // Parser phases.
    typedef enum logic [2:0] {
        PH_TAGHDR  = 3'd0,
        PH_FRMHDR  = 3'd1,
        PH_PAYLOAD = 3'd2,
        PH_SKIP    = 3'd3,
        PH_DONE    = 3'd4,
        PH_BAD     = 3'd5
    } phase_t;

    // Result kinds.
    typedef enum logic [1:0] {
        KIND_PAYLOAD = 2'd0,
        KIND_EMPTY   = 2'd1,
        KIND_BAD_HDR = 2'd2,
        KIND_END     = 2'd3
    } kind_t;

    // One result record as it travels from the parser to the output stage.
    typedef struct packed {
        kind_t       kind;
        logic [2:0]  slot;
        logic [7:0]  data;
        logic        frame_last;
        logic        all_found;
        logic        ended_early;
    } result_t;

    localparam int          TAG_HDR_LEN = 10;
    localparam int          FRM_HDR_LEN = 10;
    localparam logic [7:0]  ID3_VERSION = 8'd3;
    localparam logic [7:0]  ID3_REVISION = 8'd0;
    localparam logic [2:0]  NO_SLOT     = 3'd7;
    localparam logic [2:0]  LAST_SLOT   = 3'd5;
    localparam logic [5:0]  ALL_MASK    = 6'h3F;

    // Tag magic "ID3".
    localparam logic [7:0] TAG_MAGIC [0:2] = '{8'h49, 8'h44, 8'h33};

    // Selected frame IDs, in slot order.
    localparam logic [31:0] FRAME_IDS [0:5] = '{
        32'h54495432,   // TIT2, title
        32'h54504531,   // TPE1, artist
        32'h54414C42,   // TALB, album
        32'h54594552,   // TYER, year
        32'h54434F4E,   // TCON, genre
        32'h434F4D4D    // COMM, comment
    };

    // Slot number of a frame ID, or NO_SLOT when the frame is not selected.
    function automatic logic [2:0] lookup_slot(input logic [31:0] id);
        logic [2:0] s;
        s = NO_SLOT;
        for (int i = 5; i >= 0; i--)
        begin
            if (FRAME_IDS[i] == id)
            begin
                s = 3'(i);
            end
        end
        return s;
    endfunction

    // One-hot found bit of a slot.
    function automatic logic [5:0] slot_bit(input logic [2:0] s);
        return 6'(6'd1 << s);
    endfunction

endpackage

`default_nettype wire

FILE: rtl/i3fx_in_if.sv
// ----------------------------------------------------------------------------
// i3fx_in_if: byte input channel
// Carries one file byte and its end-of-file mark with a valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface i3fx_in_if;

    logic       valid;
    logic       ready;
    logic [7:0] tag_byte;
    logic       stream_last;

    modport source (output valid, output tag_byte, output stream_last, input ready);
    modport sink   (input valid, input tag_byte, input stream_last, output ready);

endinterface

`default_nettype wire

FILE: rtl/i3fx_out_if.sv
// ----------------------------------------------------------------------------
// i3fx_out_if: result output channel
// Carries one extractor result with a valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface i3fx_out_if;

    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [2:0] slot;
    logic [7:0] data;
    logic       frame_last;
    logic       all_found;
    logic       ended_early;

    modport source (output valid, output kind, output slot, output data,
                    output frame_last, output all_found, output ended_early,
                    input ready);
    modport sink   (input valid, input kind, input slot, input data,
                    input frame_last, input all_found, input ended_early,
                    output ready);

endinterface

`default_nettype wire

FILE: rtl/id3v23_frame_extractor.sv
// ----------------------------------------------------------------------------
// id3v23_frame_extractor: ID3v2.3 tag frame extractor, top level
// The input channel "tag" takes the file one byte per request, with
// stream_last on the final byte. The output channel "result" gives the
// payload bytes of the title, artist, album, year, genre and comment frames
// with their slot, zero-length frame markers, a bad header report and the
// end-of-file status.
// Throughput is one byte per cycle while the result queue has room: the
// parser updates its counters and compares in the cycle that a byte is
// accepted. A result is written into the result queue at the clock edge that
// accepts its byte, then moves from the queue into the output register, where
// it waits until the receiver takes it.
// When the receiver stalls, results collect in the queue (QUEUE_DEPTH entries)
// and the output register; the input keeps taking bytes until the queue is
// full, then it stops for every byte, including bytes that give no result,
// until the queue has room again. Reset empties the queue and output register
// and returns the parser to the tag header with no frames found; the block is
// ready to take bytes as soon as reset is released.
// ----------------------------------------------------------------------------
`default_nettype none

module id3v23_frame_extractor #(
    parameter int QUEUE_DEPTH = 2
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    i3fx_in_if.sink    tag,
    i3fx_out_if.source result
);

    i3fx_pkg::result_t push_data;
    logic              push_valid;
    logic              push_ready;
    i3fx_pkg::result_t pop_data;
    logic              pop_valid;
    logic              pop_ready;

    // Parser: accepts and classifies bytes.
    i3fx_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .tag        (tag),
        .push_data  (push_data),
        .push_valid (push_valid),
        .push_ready (push_ready)
    );

    // Queue between the parser and the output stage.
    i3fx_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_data  (push_data),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .pop_data   (pop_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready)
    );

    // Output register stage.
    i3fx_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_data  (pop_data),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .result    (result)
    );

endmodule

`default_nettype wire

FILE: rtl/i3fx_front.sv
// ----------------------------------------------------------------------------
// i3fx_front: tag and frame header parser
// Accepts one byte per cycle unless the queue is full, tracks the tag and
// frame headers, classifies each byte and queues at most one result for it.
// ----------------------------------------------------------------------------
`default_nettype none

module i3fx_front (
    input  wire logic          clk,
    input  wire logic          rst_n,
    i3fx_in_if.sink            tag,
    output i3fx_pkg::result_t  push_data,
    output logic               push_valid,
    input  wire logic          push_ready
);

    i3fx_pkg::phase_t phase_reg, phase_next;
    logic [3:0]       byte_pos_reg, byte_pos_next;
    logic [31:0]      frame_id_reg, frame_id_next;
    logic [31:0]      bytes_left_reg, bytes_left_next;
    logic [5:0]       found_mask_reg, found_mask_next;
    logic [2:0]       current_slot_reg, current_slot_next;

    logic             fire;
    logic             emit;
    logic             bad;
    logic [2:0]       hit_slot;
    logic [2:0]       pay_slot;
    logic [31:0]      left_dec;
    logic [5:0]       mask_set;
    i3fx_pkg::result_t res;

    // A byte is taken whenever the queue has room.
    assign tag.ready = push_ready;
    assign fire      = tag.valid && push_ready;

    // Shared helpers of the phase logic.
    assign hit_slot = i3fx_pkg::lookup_slot(frame_id_reg);
    assign pay_slot = (current_slot_reg > i3fx_pkg::LAST_SLOT) ? 3'd0 : current_slot_reg;
    assign left_dec = bytes_left_reg - 32'd1;

    // Tag header check of the current byte.
    always_comb
    begin
        bad = 1'b0;
        if (byte_pos_reg < 4'd3)
        begin
            bad = (tag.tag_byte != i3fx_pkg::TAG_MAGIC[byte_pos_reg[1:0]]);
        end
        else if (byte_pos_reg == 4'd3)
        begin
            bad = (tag.tag_byte != i3fx_pkg::ID3_VERSION);
        end
        else if (byte_pos_reg == 4'd4)
        begin
            bad = (tag.tag_byte != i3fx_pkg::ID3_REVISION);
        end
    end

    // Next state and result of the accepted byte.
    always_comb
    begin
        phase_next        = phase_reg;
        byte_pos_next     = byte_pos_reg;
        frame_id_next     = frame_id_reg;
        bytes_left_next   = bytes_left_reg;
        found_mask_next   = found_mask_reg;
        current_slot_next = current_slot_reg;
        emit              = 1'b0;
        mask_set          = '0;
        res               = '0;
        res.kind          = i3fx_pkg::KIND_PAYLOAD;

        case (phase_reg)
            i3fx_pkg::PH_TAGHDR:
            begin
                if (bad)
                begin
                    emit          = 1'b1;
                    res.kind      = i3fx_pkg::KIND_BAD_HDR;
                    phase_next    = i3fx_pkg::PH_BAD;
                    byte_pos_next = '0;
                end
                else if (byte_pos_reg == 4'(i3fx_pkg::TAG_HDR_LEN - 1))
                begin
                    phase_next    = i3fx_pkg::PH_FRMHDR;
                    byte_pos_next = '0;
                end
                else
                begin
                    byte_pos_next = byte_pos_reg + 4'd1;
                end
            end

            i3fx_pkg::PH_FRMHDR:
            begin
                if (byte_pos_reg < 4'd4)
                begin
                    frame_id_next = {frame_id_reg[23:0], tag.tag_byte};
                end
                else if (byte_pos_reg < 4'd8)
                begin
                    bytes_left_next = {bytes_left_reg[23:0], tag.tag_byte};
                end

                if (byte_pos_reg == 4'(i3fx_pkg::FRM_HDR_LEN - 1))
                begin
                    byte_pos_next     = '0;
                    current_slot_next = hit_slot;
                    if (hit_slot == i3fx_pkg::NO_SLOT)
                    begin
                        phase_next = (bytes_left_reg == '0) ? i3fx_pkg::PH_FRMHDR
                                                            : i3fx_pkg::PH_SKIP;
                    end
                    else if (bytes_left_reg == '0)
                    begin
                        // Selected frame with an empty payload.
                        emit              = 1'b1;
                        res.kind          = i3fx_pkg::KIND_EMPTY;
                        res.slot          = hit_slot;
                        res.frame_last    = 1'b1;
                        mask_set          = found_mask_reg | i3fx_pkg::slot_bit(hit_slot);
                        found_mask_next   = mask_set;
                        current_slot_next = i3fx_pkg::NO_SLOT;
                        if (mask_set == i3fx_pkg::ALL_MASK)
                        begin
                            res.all_found = 1'b1;
                            phase_next    = i3fx_pkg::PH_DONE;
                        end
                        else
                        begin
                            phase_next = i3fx_pkg::PH_FRMHDR;
                        end
                    end
                    else
                    begin
                        phase_next = i3fx_pkg::PH_PAYLOAD;
                    end
                end
                else
                begin
                    byte_pos_next = byte_pos_reg + 4'd1;
                end
            end

            i3fx_pkg::PH_PAYLOAD:
            begin
                emit            = 1'b1;
                res.kind        = i3fx_pkg::KIND_PAYLOAD;
                res.slot        = pay_slot;
                res.data        = tag.tag_byte;
                bytes_left_next = left_dec;
                if (left_dec == '0)
                begin
                    res.frame_last    = 1'b1;
                    mask_set          = found_mask_reg | i3fx_pkg::slot_bit(pay_slot);
                    found_mask_next   = mask_set;
                    current_slot_next = i3fx_pkg::NO_SLOT;
                    if (mask_set == i3fx_pkg::ALL_MASK)
                    begin
                        res.all_found = 1'b1;
                        phase_next    = i3fx_pkg::PH_DONE;
                    end
                    else
                    begin
                        phase_next    = i3fx_pkg::PH_FRMHDR;
                        frame_id_next = '0;
                    end
                end
            end

            i3fx_pkg::PH_SKIP:
            begin
                bytes_left_next = left_dec;
                if (left_dec == '0)
                begin
                    phase_next        = i3fx_pkg::PH_FRMHDR;
                    frame_id_next     = '0;
                    current_slot_next = i3fx_pkg::NO_SLOT;
                end
            end

            default:
            begin
                // Bad header or all frames found: bytes are ignored.
            end
        endcase

        // End of file: report a missing frame set, then start over.
        if (tag.stream_last)
        begin
            if (found_mask_next != i3fx_pkg::ALL_MASK)
            begin
                res.ended_early = 1'b1;
                if (!emit)
                begin
                    emit     = 1'b1;
                    res.kind = i3fx_pkg::KIND_END;
                end
            end
            phase_next        = i3fx_pkg::PH_TAGHDR;
            byte_pos_next     = '0;
            frame_id_next     = '0;
            bytes_left_next   = '0;
            found_mask_next   = '0;
            current_slot_next = i3fx_pkg::NO_SLOT;
        end
    end

    assign push_valid = fire && emit;
    assign push_data  = res;

    // State registers, updated on each accepted byte.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= i3fx_pkg::PH_TAGHDR;
            byte_pos_reg     <= '0;
            frame_id_reg     <= '0;
            bytes_left_reg   <= '0;
            found_mask_reg   <= '0;
            current_slot_reg <= i3fx_pkg::NO_SLOT;
        end
        else if (fire)
        begin
            phase_reg        <= phase_next;
            byte_pos_reg     <= byte_pos_next;
            frame_id_reg     <= frame_id_next;
            bytes_left_reg   <= bytes_left_next;
            found_mask_reg   <= found_mask_next;
            current_slot_reg <= current_slot_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/i3fx_queue.sv
// ----------------------------------------------------------------------------
// i3fx_queue: result queue
// A short first-in first-out queue that decouples the parser from the output
// stage, so that either side can stall on its own.
// ----------------------------------------------------------------------------
`default_nettype none

module i3fx_queue #(
    parameter int DEPTH = 2
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire i3fx_pkg::result_t  push_data,
    input  wire logic               push_valid,
    output logic                    push_ready,
    output i3fx_pkg::result_t       pop_data,
    output logic                    pop_valid,
    input  wire logic               pop_ready
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    i3fx_pkg::result_t mem_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              push;
    logic              pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/i3fx_back.sv
// ----------------------------------------------------------------------------
// i3fx_back: result output stage
// Moves results from the queue into the output register and holds each one
// until the receiver takes the request.
// ----------------------------------------------------------------------------
`default_nettype none

module i3fx_back (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire i3fx_pkg::result_t  pop_data,
    input  wire logic               pop_valid,
    output logic                    pop_ready,
    i3fx_out_if.source              result
);

    logic              valid_reg;
    i3fx_pkg::result_t data_reg;
    logic              load;

    // The register refills in the same cycle that its request is taken.
    assign pop_ready = !valid_reg || result.ready;
    assign load      = pop_valid && pop_ready;

    // Output valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (pop_ready)
        begin
            valid_reg <= pop_valid;
        end
    end

    // Output payload.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= pop_data;
        end
    end

    assign result.valid       = valid_reg;
    assign result.kind        = data_reg.kind;
    assign result.slot        = data_reg.slot;
    assign result.data        = data_reg.data;
    assign result.frame_last  = data_reg.frame_last;
    assign result.all_found   = data_reg.all_found;
    assign result.ended_early = data_reg.ended_early;

endmodule

`default_nettype wire

FILE: verif/id3_result_checker.sv
// ----------------------------------------------------------------------------
// id3_result_checker: result prediction and comparison for the ID3v2.3
// frame extractor
// Watches both channels of the block. Every accepted byte request is run
// through an independent model of the tag parser. The model queues the result
// that the byte should cause, if any. Every accepted result request is
// compared field by field with the oldest queued result. It reports the count
// of failures and the number of results still awaited.
// ----------------------------------------------------------------------------
`default_nettype none

module id3_result_checker
    import i3fx_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    i3fx_in_if        tag,
    i3fx_out_if       result,
    output int        fail_count,
    output int        outstanding
);

    // Parser model state.
    phase_t      parse_phase;
    logic [3:0]  hdr_pos;
    logic [31:0] cur_id;
    logic [31:0] remaining;
    logic [5:0]  seen_slots;
    logic [2:0]  active_slot;

    result_t     expected_results[$];

    // Slot of a frame ID, or NO_SLOT for frames that are skipped.
    function automatic logic [2:0] slot_of_id(input logic [31:0] id);
        case (id)
            "TIT2":  return 3'd0;
            "TPE1":  return 3'd1;
            "TALB":  return 3'd2;
            "TYER":  return 3'd3;
            "TCON":  return 3'd4;
            "COMM":  return 3'd5;
            default: return NO_SLOT;
        endcase
    endfunction

    task automatic clear_parse_state();
        parse_phase = PH_TAGHDR;
        hdr_pos     = '0;
        cur_id      = '0;
        remaining   = '0;
        seen_slots  = '0;
        active_slot = NO_SLOT;
    endtask

    // Advance the parser model by one byte and queue the result it causes.
    task automatic predict_byte(input logic [7:0] b, input logic last);
        result_t    r;
        logic       emit;
        logic       bad;
        logic [2:0] s;
        r    = '0;
        emit = 1'b0;
        bad  = 1'b0;
        case (parse_phase)
            PH_TAGHDR:
            begin
                if (hdr_pos < 4'd3)
                begin
                    bad = (b != TAG_MAGIC[hdr_pos]);
                end
                else if (hdr_pos == 4'd3)
                begin
                    bad = (b != ID3_VERSION);
                end
                else if (hdr_pos == 4'd4)
                begin
                    bad = (b != ID3_REVISION);
                end
                if (bad)
                begin
                    emit        = 1'b1;
                    r.kind      = KIND_BAD_HDR;
                    parse_phase = PH_BAD;
                    hdr_pos     = '0;
                end
                else if (hdr_pos == 4'(TAG_HDR_LEN - 1))
                begin
                    parse_phase = PH_FRMHDR;
                    hdr_pos     = '0;
                end
                else
                begin
                    hdr_pos = hdr_pos + 4'd1;
                end
            end
            PH_FRMHDR:
            begin
                // ID bytes first, then the size bytes, both big-endian.
                if (hdr_pos < 4'd4)
                begin
                    cur_id = {cur_id[23:0], b};
                end
                else if (hdr_pos < 4'd8)
                begin
                    remaining = {remaining[23:0], b};
                end
                if (hdr_pos == 4'(FRM_HDR_LEN - 1))
                begin
                    s           = slot_of_id(cur_id);
                    hdr_pos     = '0;
                    active_slot = s;
                    if (s == NO_SLOT)
                    begin
                        parse_phase = (remaining == 0) ? PH_FRMHDR : PH_SKIP;
                    end
                    else if (remaining == 0)
                    begin
                        emit         = 1'b1;
                        r.kind       = KIND_EMPTY;
                        r.slot       = s;
                        r.frame_last = 1'b1;
                        seen_slots   = seen_slots | 6'(6'd1 << s);
                        active_slot  = NO_SLOT;
                        if (seen_slots == ALL_MASK)
                        begin
                            r.all_found = 1'b1;
                            parse_phase = PH_DONE;
                        end
                        else
                        begin
                            parse_phase = PH_FRMHDR;
                        end
                    end
                    else
                    begin
                        parse_phase = PH_PAYLOAD;
                    end
                end
                else
                begin
                    hdr_pos = hdr_pos + 4'd1;
                end
            end
            PH_PAYLOAD:
            begin
                s = (active_slot > LAST_SLOT) ? 3'd0 : active_slot;
                emit      = 1'b1;
                r.kind    = KIND_PAYLOAD;
                r.slot    = s;
                r.data    = b;
                remaining = remaining - 32'd1;
                if (remaining == 0)
                begin
                    r.frame_last = 1'b1;
                    seen_slots   = seen_slots | 6'(6'd1 << s);
                    active_slot  = NO_SLOT;
                    if (seen_slots == ALL_MASK)
                    begin
                        r.all_found = 1'b1;
                        parse_phase = PH_DONE;
                    end
                    else
                    begin
                        parse_phase = PH_FRMHDR;
                        cur_id      = '0;
                    end
                end
            end
            PH_SKIP:
            begin
                remaining = remaining - 32'd1;
                if (remaining == 0)
                begin
                    parse_phase = PH_FRMHDR;
                    cur_id      = '0;
                    active_slot = NO_SLOT;
                end
            end
            default:
            begin
            end
        endcase

        // The final byte of a file reports an incomplete set and restarts.
        if (last)
        begin
            if (seen_slots != ALL_MASK)
            begin
                r.ended_early = 1'b1;
                if (!emit)
                begin
                    emit   = 1'b1;
                    r.kind = KIND_END;
                end
            end
            clear_parse_state();
        end
        if (emit)
        begin
            expected_results.push_back(r);
        end
    endtask

    // Compare one accepted result with the oldest expectation.
    task automatic check_result();
        result_t got;
        result_t want;
        got = {result.kind, result.slot, result.data, result.frame_last,
               result.all_found, result.ended_early};
        if (expected_results.size() == 0)
        begin
            fail_count++;
            if (fail_count <= 10)
            begin
                $display("unexpected result: kind=%0d slot=%0d data=%02h last=%0b all=%0b early=%0b",
                         got.kind, got.slot, got.data, got.frame_last, got.all_found,
                         got.ended_early);
            end
        end
        else
        begin
            want = expected_results.pop_front();
            if (got.kind !== want.kind || got.slot !== want.slot || got.data !== want.data
                || got.frame_last !== want.frame_last || got.all_found !== want.all_found
                || got.ended_early !== want.ended_early)
            begin
                fail_count++;
                if (fail_count <= 10)
                begin
                    $display("mismatch: expected kind=%0d slot=%0d data=%02h last=%0b all=%0b early=%0b",
                             want.kind, want.slot, want.data, want.frame_last,
                             want.all_found, want.ended_early);
                    $display("          actual   kind=%0d slot=%0d data=%02h last=%0b all=%0b early=%0b",
                             got.kind, got.slot, got.data, got.frame_last, got.all_found,
                             got.ended_early);
                end
            end
        end
    endtask

    // Sample both channels at the clock edge where requests are accepted.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_parse_state();
            expected_results.delete();
            fail_count  = 0;
            outstanding = 0;
        end
        else
        begin
            if (tag.valid && tag.ready)
            begin
                predict_byte(tag.tag_byte, tag.stream_last);
            end
            if (result.valid && result.ready)
            begin
                check_result();
            end
            outstanding = expected_results.size();
        end
    end

endmodule

`default_nettype wire

FILE: verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: testbench for the ID3v2.3 frame extractor
// Builds tag files byte by byte and sends them to the block: a few handmade
// files for the header checks, truncation and completion, then random files
// that are mostly well formed, with broken headers, oversized frames and
// noise mixed in. Sender and receiver idle at random in two of three phases;
// the last phase holds the receiver off for a long stretch. The checker
// beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
    import i3fx_pkg::*;

    localparam int TARGET_BYTES   = 950;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int HOLDOFF_CYCLES = 300;
    localparam int SETTLE_CYCLES  = 10;
    localparam int HEADER_INTACT  = 5;
    localparam int RANDOM_FILL    = -1;
    localparam int CUT_SIZE       = 4096;

    logic clk;
    logic rst_n;

    i3fx_in_if  tag_ch ();
    i3fx_out_if result_ch ();

    int send_idle_pct;
    int recv_idle_pct;
    int holdoff_requests;
    int holdoff_served;
    int holdoff_left;
    int stall_cycles;
    int sent_total;
    int mismatch_count;
    int outstanding;

    logic [7:0] file_bytes[$];

    id3v23_frame_extractor i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .tag    (tag_ch),
        .result (result_ch)
    );

    id3_result_checker i_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .tag         (tag_ch),
        .result      (result_ch),
        .fail_count  (mismatch_count),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Receiver: random stalls, plus a long hold-off whenever one is requested.
    initial
    begin
        result_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (holdoff_left > 0)
            begin
                holdoff_left--;
                result_ch.ready <= 1'b0;
            end
            else if (holdoff_served != holdoff_requests)
            begin
                holdoff_served = holdoff_requests;
                holdoff_left   = HOLDOFF_CYCLES;
                result_ch.ready <= 1'b0;
            end
            else
            begin
                result_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Watchdog on cycles in which neither channel moves a request.
    always @(posedge clk)
    begin
        if ((tag_ch.valid && tag_ch.ready) || (result_ch.valid && result_ch.ready))
        begin
            stall_cycles = 0;
        end
        else
        begin
            stall_cycles++;
        end
        if (stall_cycles >= WATCHDOG_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Ten-byte tag header; one of the checked bytes is spoiled on request.
    task automatic add_header(input int corrupt_pos);
        logic [7:0] hdr[10];
        hdr[0] = TAG_MAGIC[0];
        hdr[1] = TAG_MAGIC[1];
        hdr[2] = TAG_MAGIC[2];
        hdr[3] = ID3_VERSION;
        hdr[4] = ID3_REVISION;
        for (int i = 5; i < 10; i++)
        begin
            hdr[i] = 8'($urandom);
        end
        if (corrupt_pos < HEADER_INTACT)
        begin
            hdr[corrupt_pos] = hdr[corrupt_pos] ^ 8'($urandom_range(1, 255));
        end
        for (int i = 0; i < 10; i++)
        begin
            file_bytes.push_back(hdr[i]);
        end
    endtask

    // One frame. Huge sizes only get a short body, as the file ends inside it.
    task automatic add_frame(input logic [31:0] id, input logic [31:0] size, input int fill);
        int body;
        body = (size < CUT_SIZE) ? int'(size) : $urandom_range(1, 15);
        for (int i = 3; i >= 0; i--)
        begin
            file_bytes.push_back(id[8*i +: 8]);
        end
        for (int i = 3; i >= 0; i--)
        begin
            file_bytes.push_back(size[8*i +: 8]);
        end
        repeat (2) file_bytes.push_back(8'($urandom));
        repeat (body) file_bytes.push_back((fill < 0) ? 8'($urandom) : 8'(fill));
    endtask

    function automatic logic [31:0] random_id();
        int r;
        r = $urandom_range(99);
        if (r < 65)
        begin
            return FRAME_IDS[$urandom_range(0, 5)];
        end
        else if (r < 85)
        begin
            // Near miss: a selected ID with one bit flipped.
            return FRAME_IDS[$urandom_range(0, 5)] ^ (32'd1 << $urandom_range(0, 31));
        end
        return $urandom;
    endfunction

    function automatic logic [31:0] random_size();
        int r;
        r = $urandom_range(99);
        if (r < 60)
        begin
            return $urandom_range(0, 6);
        end
        else if (r < 85)
        begin
            return $urandom_range(7, 20);
        end
        else if (r < 95)
        begin
            return 0;
        end
        return $urandom_range(21, 60);
    endfunction

    task automatic cut_file(input int keep);
        while (file_bytes.size() > keep)
        begin
            void'(file_bytes.pop_back());
        end
    endtask

    task automatic build_random_file();
        int         pick;
        int         j;
        int         bad_pos;
        logic [2:0] order[6];
        logic [2:0] tmp;
        pick = $urandom_range(99);
        if (pick < 60)
        begin
            // Well-formed tag, often with the full set in random order.
            add_header(HEADER_INTACT);
            if ($urandom_range(1) == 1)
            begin
                for (int k = 0; k < 6; k++)
                begin
                    order[k] = 3'(k);
                end
                for (int k = 5; k > 0; k--)
                begin
                    j        = $urandom_range(0, k);
                    tmp      = order[k];
                    order[k] = order[j];
                    order[j] = tmp;
                end
                for (int k = 0; k < 6; k++)
                begin
                    if ($urandom_range(3) == 0)
                    begin
                        add_frame(random_id(), random_size(), RANDOM_FILL);
                    end
                    add_frame(FRAME_IDS[order[k]], random_size(), RANDOM_FILL);
                end
            end
            else
            begin
                repeat ($urandom_range(1, 6)) add_frame(random_id(), random_size(), RANDOM_FILL);
            end
            repeat ($urandom_range(0, 3))
                file_bytes.push_back(($urandom_range(3) == 0) ? 8'($urandom) : 8'h00);
            if ($urandom_range(6) == 0)
            begin
                cut_file($urandom_range(1, file_bytes.size()));
            end
        end
        else if (pick < 75)
        begin
            // File that ends inside a frame of huge declared size.
            add_header(HEADER_INTACT);
            repeat ($urandom_range(0, 2)) add_frame(random_id(), random_size(), RANDOM_FILL);
            add_frame(random_id(), $urandom | CUT_SIZE, RANDOM_FILL);
        end
        else if (pick < 90)
        begin
            // Spoiled header, or a header that is cut short.
            bad_pos = $urandom_range(0, HEADER_INTACT);
            add_header(bad_pos);
            if (bad_pos == HEADER_INTACT)
            begin
                cut_file($urandom_range(1, TAG_HDR_LEN - 1));
            end
            else
            begin
                cut_file($urandom_range(bad_pos + 1, TAG_HDR_LEN));
                repeat ($urandom_range(0, 4)) file_bytes.push_back(8'($urandom));
            end
        end
        else
        begin
            repeat ($urandom_range(1, 12)) file_bytes.push_back(8'($urandom));
        end
    endtask

    task automatic send_byte(input logic [7:0] b, input logic last);
        while ($urandom_range(99) < send_idle_pct)
        begin
            tag_ch.valid <= 1'b0;
            @(posedge clk);
        end
        tag_ch.valid       <= 1'b1;
        tag_ch.tag_byte    <= b;
        tag_ch.stream_last <= last;
        @(posedge clk);
        while (!tag_ch.ready)
        begin
            @(posedge clk);
        end
    endtask

    // Send the built file; its final byte carries stream_last.
    task automatic send_file();
        int n;
        n = file_bytes.size();
        for (int i = 0; i < n; i++)
        begin
            send_byte(file_bytes[i], i == n - 1);
        end
        sent_total += n;
        file_bytes.delete();
    endtask

    // Pause the sender until every predicted result has come out.
    task automatic wait_drained();
        tag_ch.valid <= 1'b0;
        @(negedge clk);
        while (outstanding != 0)
        begin
            @(negedge clk);
        end
        @(posedge clk);
    endtask

    initial
    begin
        rst_n              <= 1'b0;
        tag_ch.valid       <= 1'b0;
        tag_ch.tag_byte    <= 8'h00;
        tag_ch.stream_last <= 1'b0;
        send_idle_pct = 7;
        recv_idle_pct = 82;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Full set with extreme payload bytes, a skipped frame, an empty
        // unknown frame and a repeated title; the final byte completes the set.
        add_header(HEADER_INTACT);
        add_frame(FRAME_IDS[0], 1, 8'h00);
        add_frame(FRAME_IDS[1], 0, 0);
        add_frame("PRIV", 2, RANDOM_FILL);
        add_frame("XXXX", 0, RANDOM_FILL);
        add_frame(FRAME_IDS[0], 2, 8'hFF);
        add_frame(FRAME_IDS[2], 1, RANDOM_FILL);
        add_frame(FRAME_IDS[3], 0, 0);
        add_frame(FRAME_IDS[4], 1, 8'h80);
        add_frame(FRAME_IDS[5], 2, 8'h7F);
        send_file();

        // A spoiled byte at each checked header position.
        for (int p = 0; p < HEADER_INTACT; p++)
        begin
            add_header(p);
            send_file();
        end

        // One-byte files: bad first byte and end on the same byte, then a
        // good first byte that ends the file with nothing found.
        file_bytes.push_back(8'h00);
        send_file();
        file_bytes.push_back(TAG_MAGIC[0]);
        send_file();

        // File that ends inside the payload of a selected frame.
        add_header(HEADER_INTACT);
        add_frame(FRAME_IDS[5], 5, RANDOM_FILL);
        cut_file(file_bytes.size() - 3);
        send_file();

        while (sent_total < TARGET_BYTES / 3)
        begin
            build_random_file();
            send_file();
        end
        wait_drained();

        send_idle_pct = 82;
        recv_idle_pct = 7;
        while (sent_total < 2 * TARGET_BYTES / 3)
        begin
            build_random_file();
            send_file();
        end
        wait_drained();

        // No idling; the receiver is held off while bytes keep coming.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        holdoff_requests++;
        while (sent_total < TARGET_BYTES)
        begin
            build_random_file();
            send_file();
        end
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
        begin
            $display("RESULT: OK");
        end
        else
        begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire

FILE: files.f
rtl/i3fx_pkg.sv
rtl/i3fx_in_if.sv
rtl/i3fx_out_if.sv
rtl/i3fx_front.sv
rtl/i3fx_queue.sv
rtl/i3fx_back.sv
rtl/id3v23_frame_extractor.sv
verif/id3_result_checker.sv
verif/tb_top.sv
